@@ rtl/itda_pkg.sv @@
// itda_pkg: shared types and constants for the integer to decimal text converter
// no dependencies; imported by the converter modules
package itda_pkg;

  // width of one packed decimal digit
  localparam int unsigned DIGIT_W = 4;

  // ascii codes used on the character channel
  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_MINUS = 8'h2D;

  // largest value of one decimal digit
  localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SCAN,
    ST_SIGN,
    ST_DIGITS
  } itda_state_e;

endpackage

@@ rtl/itda_in_if.sv @@
// itda_in_if: valid/ready channel carrying one signed integer
// no dependencies
interface itda_in_if #(
  parameter int unsigned VALUE_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

@@ rtl/itda_out_if.sv @@
// itda_out_if: valid/ready channel carrying one ascii character and a last flag
// no dependencies
interface itda_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

@@ rtl/itda_dabble.sv @@
// itda_dabble: one shift-and-add-3 step of binary to packed bcd conversion
// depends on itda_pkg
module itda_dabble
  import itda_pkg::*;
#(
  parameter int unsigned NUM_DIGITS = 10
) (
  input  logic [NUM_DIGITS*DIGIT_W-1:0] bcd_i,
  input  logic                          bit_i,
  output logic [NUM_DIGITS*DIGIT_W-1:0] bcd_o
);

  logic [NUM_DIGITS*DIGIT_W-1:0] adj;

  // add 3 to every digit of 5 or more so the shift carries into the next digit
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_i[i*DIGIT_W +: DIGIT_W] >= 4'd5) begin
        adj[i*DIGIT_W +: DIGIT_W] = bcd_i[i*DIGIT_W +: DIGIT_W] + 4'd3;
      end else begin
        adj[i*DIGIT_W +: DIGIT_W] = bcd_i[i*DIGIT_W +: DIGIT_W];
      end
    end
  end

  // shift in the next magnitude bit
  assign bcd_o = {adj[NUM_DIGITS*DIGIT_W-2:0], bit_i};

endmodule

@@ rtl/int_to_decimal_ascii.sv @@
// int_to_decimal_ascii: signed integer to decimal ascii text, one character per transfer
// depends on itda_pkg, itda_in_if, itda_out_if and itda_dabble
//
//  port    | dir | payload                 | meaning
//  in_i    | in  | value [VALUE_WIDTH]     | signed integer to convert
//  out_o   | out | character [8], last [1] | text, most significant first; last on final char
//
// a value is converted one magnitude bit per cycle through the shared shift-add-3 unit,
// then sent as characters: sign if negative, then digits. in_i is ready only between values.
// the result channel has an output register, so the next value is taken while the last
// character still waits. stalls on out_o hold the sequencer. reset clears control only.
module int_to_decimal_ascii
  import itda_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  itda_in_if.sink    in_i,
  itda_out_if.source out_o
);

  // digits enough for a magnitude of 2^(VALUE_WIDTH-1)
  localparam int unsigned NUM_DIGITS = (VALUE_WIDTH * 3) / 10 + 1;
  localparam int unsigned BCD_W      = NUM_DIGITS * DIGIT_W;
  localparam int unsigned IDX_W      = $clog2(NUM_DIGITS);
  localparam int unsigned CNT_W      = $clog2(VALUE_WIDTH);

  itda_state_e             state_q, state_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic [IDX_W-1:0]        idx_q, idx_d;
  logic                    neg_q, neg_d;
  logic [VALUE_WIDTH-1:0]  mag_q, mag_d;
  logic [BCD_W-1:0]        bcd_q, bcd_d;
  logic                    out_valid_q, out_valid_d;
  logic [7:0]              char_q, char_d;
  logic                    last_q, last_d;

  logic                    in_fire;
  logic                    emit_ok;
  logic [BCD_W-1:0]        bcd_step;
  logic [IDX_W-1:0]        msd;
  logic [DIGIT_W-1:0]      cur_digit;
  logic [VALUE_WIDTH-1:0]  in_raw;

  // shared conversion unit
  itda_dabble #(
    .NUM_DIGITS(NUM_DIGITS)
  ) u_dabble (
    .bcd_i (bcd_q),
    .bit_i (mag_q[VALUE_WIDTH-1]),
    .bcd_o (bcd_step)
  );

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign in_raw     = in_i.value;
  assign emit_ok    = !out_valid_q || out_o.ready;
  assign cur_digit  = bcd_q[{idx_q, 2'b00} +: DIGIT_W];

  // most significant nonzero digit, zero when the value is zero
  always_comb begin
    msd = '0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_q[i*DIGIT_W +: DIGIT_W] != '0) begin
        msd = IDX_W'(i);
      end
    end
  end

  // sequencer next state and datapath loads
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    neg_d       = neg_q;
    mag_d       = mag_q;
    bcd_d       = bcd_q;
    out_valid_d = out_valid_q && !out_o.ready;
    char_d      = char_q;
    last_d      = last_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          neg_d   = in_raw[VALUE_WIDTH-1];
          mag_d   = in_raw[VALUE_WIDTH-1] ? ('0 - in_raw) : in_raw;
          bcd_d   = '0;
          cnt_d   = CNT_W'(VALUE_WIDTH - 1);
          state_d = ST_CONV;
        end
      end
      ST_CONV: begin
        bcd_d = bcd_step;
        mag_d = {mag_q[VALUE_WIDTH-2:0], 1'b0};
        if (cnt_q == '0) begin
          state_d = ST_SCAN;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      ST_SCAN: begin
        idx_d   = msd;
        state_d = neg_q ? ST_SIGN : ST_DIGITS;
      end
      ST_SIGN: begin
        if (emit_ok) begin
          out_valid_d = 1'b1;
          char_d      = ASCII_MINUS;
          last_d      = 1'b0;
          state_d     = ST_DIGITS;
        end
      end
      ST_DIGITS: begin
        if (emit_ok) begin
          out_valid_d = 1'b1;
          char_d      = ASCII_ZERO + {4'd0, cur_digit};
          last_d      = (idx_q == '0);
          if (idx_q == '0) begin
            state_d = ST_IDLE;
          end else begin
            idx_d = idx_q - 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    cnt_q  <= cnt_d;
    idx_q  <= idx_d;
    neg_q  <= neg_d;
    mag_q  <= mag_d;
    bcd_q  <= bcd_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.character = char_q;
  assign out_o.last      = last_q;

  // a taken value always starts conversion
  a_start_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == ST_CONV)
    else $error("accepted value did not start conversion");

  // conversion ends after the final magnitude bit
  a_conv_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CONV && cnt_q == '0) |=> state_q == ST_SCAN)
    else $error("conversion did not end on last bit");

  // every digit left by the shift-add-3 unit is decimal
  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIGITS |-> cur_digit <= DIGIT_MAX)
    else $error("bcd digit out of range");

  // the final character returns the sequencer to idle with last set
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIGITS && emit_ok && idx_q == '0) |=>
      (state_q == ST_IDLE && out_valid_q && last_q))
    else $error("final character did not close the run");

endmodule

@@ verif/int_to_decimal_ascii_test.sv @@
// int_to_decimal_ascii_test: self-checking bench for the integer to decimal text converter
// depends on itda_pkg, itda_in_if, itda_out_if and int_to_decimal_ascii; a small class
// predicts each value's characters and checks every character transfer against them
`timescale 1ns / 100ps

module int_to_decimal_ascii_test;
  import itda_pkg::*;

  localparam int unsigned VALUE_WIDTH  = 32;
  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned DRAIN_CYCLES = 60;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned RANDOM_COUNT = 240;
  localparam int unsigned PRINT_LIMIT  = 50;

  // one expected character of a number's text
  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } text_char_t;

  // predicts decimal text and checks character transfers in order
  class text_scoreboard;
    text_char_t  pending_q[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    task report_mismatch(input string what);
      mismatches++;
      if (mismatches <= PRINT_LIMIT)
        $display("%0t mismatch: %s", $time, what);
    endtask

    // queue the characters of one accepted value, sign first
    function void note_value(input logic [VALUE_WIDTH-1:0] value);
      logic [VALUE_WIDTH-1:0] magnitude;
      logic [7:0]             digit_q[$];
      text_char_t             entry;
      int                     k;
      magnitude = value[VALUE_WIDTH-1] ? (~value + 1'b1) : value;
      // least significant digit first
      do begin
        digit_q.push_back(ASCII_ZERO + 8'(magnitude % 10));
        magnitude = magnitude / 10;
      end while (magnitude != 0);
      if (value[VALUE_WIDTH-1]) begin
        entry.code = ASCII_MINUS;
        entry.last = 1'b0;
        pending_q.push_back(entry);
      end
      for (k = digit_q.size() - 1; k >= 0; k--) begin
        entry.code = digit_q[k];
        entry.last = (k == 0);
        pending_q.push_back(entry);
      end
    endfunction

    // compare one character transfer with the oldest expectation
    task check_char(input logic [7:0] code, input logic last);
      text_char_t want;
      if (pending_q.size() == 0) begin
        report_mismatch($sformatf("character 8'h%02h with no value pending", code));
      end else begin
        want = pending_q.pop_front();
        if (code !== want.code)
          report_mismatch($sformatf("character 8'h%02h, expected 8'h%02h", code, want.code));
        if (last !== want.last)
          report_mismatch($sformatf("last %b on 8'h%02h, expected %b", last, code, want.last));
      end
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  bit   hold_req;

  text_scoreboard sb = new();

  itda_in_if #(.VALUE_WIDTH(VALUE_WIDTH)) in_ch ();
  itda_out_if out_ch ();

  int_to_decimal_ascii #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  // clock
  always #5 clk_i = ~clk_i;

  // offer one value and wait for its transfer
  task automatic offer_value(input logic [VALUE_WIDTH-1:0] value);
    in_ch.valid <= 1'b1;
    in_ch.value <= value;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    sb.note_value(value);
  endtask

  // idle gap between bursts
  task automatic pause_sender(input int unsigned cycles);
    if (cycles != 0) begin
      in_ch.valid <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // random value with weight on short numbers, decade edges and range ends
  function automatic logic [VALUE_WIDTH-1:0] pick_value();
    logic [VALUE_WIDTH-1:0] v;
    int unsigned            k;
    case ($urandom_range(0, 4)) inside
      0, 1: v = $urandom;
      2: v = $urandom_range(0, 999);
      3: begin
        v = 1;
        k = $urandom_range(0, 9);
        repeat (k) v = v * 10;
        v = v + $urandom_range(0, 2) - 1;
      end
      default: v = 32'h7FFF_FFFF - $urandom_range(0, 3);
    endcase
    if ($urandom_range(0, 1) == 1)
      v = ~v + 1'b1;
    return v;
  endfunction

  // character transfers go to the checker
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready)
      sb.check_char(out_ch.character, out_ch.last);
  end

  // receiver: stretches of random readiness, plus one long hold-off on request
  initial begin : receiver
    int unsigned span;
    int unsigned pct;
    int unsigned n;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        for (n = 0; n < HOLD_CYCLES; n++) begin
          @(posedge clk_i);
          out_ch.ready <= 1'b0;
        end
      end
      span = $urandom_range(5, 60);
      case ($urandom_range(0, 3))
        0: pct = 100;
        1: pct = 75;
        2: pct = 40;
        default: pct = 10;
      endcase
      for (n = 0; n < span; n++) begin
        @(posedge clk_i);
        out_ch.ready <= ($urandom_range(1, 100) <= pct);
      end
    end
  end

  // watchdog on cycles without any transfer
  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // stimulus
  initial begin : stimulus
    logic [VALUE_WIDTH-1:0] value_q[$];
    int unsigned            idx;
    int unsigned            burst;
    int unsigned            n;
    bit                     held;
    rst_ni      = 1'b0;
    hold_req    = 1'b0;
    held        = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.value = '0;

    // zero, single digits, decade edges, extremes and the most negative value
    value_q = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
                32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1000000000,
                32'd999999999, -32'sd999999999, 32'd123456789, -32'sd5,
                32'h5555_5555, 32'hAAAA_AAAA, -32'sd1000000000, 32'd4000000};
    for (n = 0; n < RANDOM_COUNT; n++)
      value_q.push_back(pick_value());

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // bursts of transfers with random gaps
    idx = 0;
    while (idx < value_q.size()) begin
      // one long receiver hold-off partway through the run
      if (idx >= 100 && !held) begin
        hold_req = 1'b1;
        held     = 1'b1;
      end
      burst = $urandom_range(1, 12);
      for (n = 0; n < burst && idx < value_q.size(); n++) begin
        offer_value(value_q[idx]);
        idx++;
      end
      if ($urandom_range(0, 3) != 0)
        pause_sender($urandom_range(1, 15));
    end
    in_ch.valid <= 1'b0;

    // drain
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.pending_q.size() != 0)
      sb.report_mismatch($sformatf("%0d characters never arrived", sb.pending_q.size()));

    if (sb.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
